// ===== src/rse_pkg.sv =====
// Shared types and constants for the RPN stack evaluator.
// Token and status codes, plus the command and status structs that join
// the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic [2:0] t_cmd_code;
    typedef logic [2:0] t_status;

    // Token codes.
    localparam t_cmd_code CMD_DIGIT     = 3'd0;
    localparam t_cmd_code CMD_ADD       = 3'd1;
    localparam t_cmd_code CMD_SUB       = 3'd2;
    localparam t_cmd_code CMD_MUL       = 3'd3;
    localparam t_cmd_code CMD_DIV       = 3'd4;
    localparam t_cmd_code CMD_END       = 3'd5;
    localparam t_cmd_code CMD_MALFORMED = 3'd6;

    // Status codes.
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_UNDERFLOW  = 3'd1;
    localparam t_status ST_DIVZERO    = 3'd2;
    localparam t_status ST_RANGE      = 3'd3;
    localparam t_status ST_MALFORMED  = 3'd4;
    localparam t_status ST_INCOMPLETE = 3'd5;
    localparam t_status ST_FULL       = 3'd6;

    localparam logic [DATA_W-1:0] INT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};

    // Source of the value written to the top of stack when an operator commits.
    typedef enum logic [1:0] {
        SRC_ADDSUB = 2'd0,
        SRC_MUL    = 2'd1,
        SRC_DIV    = 2'd2
    } t_src;

    typedef struct packed {
        logic    capture;
        logic    push;
        logic    set_err;
        t_status err_code;
        logic    rd_second;
        logic    mul_load;
        logic    div_start;
        logic    commit;
        t_src    src;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      err_set;
        logic      full;
        logic      lt2;
        logic      addsub_ovf;
        logic      mul_ovf;
        logic      b_zero;
        logic      div_ovf;
        logic      div_done;
        logic      out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/rse_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Quotient truncates toward zero. Uses rse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rse_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rse_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [rse_pkg::DATA_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [rse_pkg::DATA_W-1:0]     o_quotient
);
    import rse_pkg::*;

    localparam int unsigned STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W+1:0] w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_diff[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
            r_dvs <= i_divisor[DATA_W-1] ? (~i_divisor + DATA_W'(1)) : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

endmodule

`default_nettype wire

// ===== src/rse_datapath.sv =====
// Datapath of the RPN evaluator: operand stack memory, cached top of stack,
// adder, multiplier, divider and the output register. Uses rse_pkg, rse_div.
`timescale 1ns / 1ps
`default_nettype none

module rse_datapath #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rse_pkg::t_dp_cmd           i_cmd,
    output rse_pkg::t_dp_stat               o_stat,
    input  wire rse_pkg::t_cmd_code         i_tok_cmd,
    input  wire logic [3:0]                 i_tok_digit,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rse_pkg::t_status                o_status,
    output logic signed [rse_pkg::DATA_W-1:0] o_value,
    output logic                            o_finished
);
    import rse_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    // The top of stack lives in r_top; the memory holds the entries below it.
    logic [DATA_W-1:0] r_stack_mem [STACK_DEPTH];

    t_cmd_code          r_cmd;
    logic [3:0]         r_digit;
    logic [DATA_W-1:0]  r_top,   n_top;
    logic [CW-1:0]      r_count, n_count;
    t_status            r_err,   n_err;
    logic [DATA_W-1:0]  r_rdata;
    logic signed [2*DATA_W-1:0] r_prod;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [DATA_W-1:0]  r_out_value;
    logic               r_out_finished;

    logic [CW-1:0]      w_cnt_m1;
    logic [CW-1:0]      w_cnt_m2;
    logic [DATA_W:0]    w_addsub;
    logic               w_div_done;
    logic [DATA_W-1:0]  w_quotient;
    logic [DATA_W-1:0]  w_result;
    logic               w_is_end;
    t_status            w_resp_status;
    logic [DATA_W-1:0]  w_resp_value;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_is_end = (r_cmd == CMD_END);

    // Second operand is r_rdata, first popped operand is the cached top.
    assign w_addsub = (r_cmd == CMD_SUB)
                    ? ({r_rdata[DATA_W-1], r_rdata} - {r_top[DATA_W-1], r_top})
                    : ({r_rdata[DATA_W-1], r_rdata} + {r_top[DATA_W-1], r_top});

    rse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rdata),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        case (i_cmd.src)
            SRC_ADDSUB: w_result = w_addsub[DATA_W-1:0];
            SRC_MUL:    w_result = r_prod[DATA_W-1:0];
            SRC_DIV:    w_result = w_quotient;
            default:    w_result = w_addsub[DATA_W-1:0];
        endcase
    end

    always_comb begin
        if (w_is_end) begin
            if (r_err != ST_OK) begin
                w_resp_status = r_err;
                w_resp_value  = '0;
            end else if (r_count == CW'(1)) begin
                w_resp_status = ST_OK;
                w_resp_value  = r_top;
            end else begin
                w_resp_status = ST_INCOMPLETE;
                w_resp_value  = '0;
            end
        end else begin
            w_resp_status = r_err;
            w_resp_value  = (r_count != '0) ? r_top : '0;
        end
    end

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        n_err   = r_err;
        if (i_cmd.push) begin
            n_top   = {{(DATA_W-4){1'b0}}, r_digit};
            n_count = r_count + CW'(1);
        end
        if (i_cmd.commit) begin
            n_top   = w_result;
            n_count = w_cnt_m1;
        end
        if (i_cmd.set_err) begin
            n_err = i_cmd.err_code;
        end
        if (i_cmd.out_load && w_is_end) begin
            n_count = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (i_cmd.capture) begin
            r_cmd   <= i_tok_cmd;
            r_digit <= i_tok_digit;
        end
        if (i_cmd.mul_load) begin
            r_prod <= $signed(r_rdata) * $signed(r_top);
        end
        if (i_cmd.out_load) begin
            r_out_status   <= w_resp_status;
            r_out_value    <= w_resp_value;
            r_out_finished <= w_is_end;
        end
    end

    // Stack memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_count != '0)) begin
            r_stack_mem[w_cnt_m1[AW-1:0]] <= r_top;
        end
        if (i_cmd.rd_second) begin
            r_rdata <= r_stack_mem[w_cnt_m2[AW-1:0]];
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.err_set    = (r_err != ST_OK);
        o_stat.full       = (r_count >= CW'(STACK_DEPTH));
        o_stat.lt2        = (r_count < CW'(2));
        o_stat.addsub_ovf = w_addsub[DATA_W] ^ w_addsub[DATA_W-1];
        o_stat.mul_ovf    = !((&r_prod[2*DATA_W-1:DATA_W-1]) ||
                              (~|r_prod[2*DATA_W-1:DATA_W-1]));
        o_stat.b_zero     = (r_top == '0);
        o_stat.div_ovf    = (r_rdata == INT_MIN) && (r_top == MINUS_ONE);
        o_stat.div_done   = w_div_done;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;
    assign o_finished  = r_out_finished;

endmodule

`default_nettype wire

// ===== src/rse_ctrl.sv =====
// Controller of the RPN evaluator: sequences each token through decode,
// operand fetch, arithmetic and response. Uses rse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rse_pkg::t_dp_stat i_stat,
    output rse_pkg::t_dp_cmd       o_cmd
);
    import rse_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_EXEC   = 6'b000100,
        S_MULCHK = 6'b001000,
        S_DIVW   = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                if (i_stat.cmd == CMD_END || i_stat.err_set) begin
                    n_state = S_RESP;
                end else if (i_stat.cmd == CMD_DIGIT) begin
                    if (i_stat.full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_stat.cmd inside {[CMD_ADD:CMD_DIV]}) begin
                    if (i_stat.lt2) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_UNDERFLOW;
                    end else begin
                        o_cmd.rd_second = 1'b1;
                        n_state         = S_EXEC;
                    end
                end else begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_MALFORMED;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_stat.cmd)
                    CMD_MUL: begin
                        o_cmd.mul_load = 1'b1;
                        n_state        = S_MULCHK;
                    end
                    CMD_DIV: begin
                        if (i_stat.b_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_DIVZERO;
                        end else if (i_stat.div_ovf) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_RANGE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIVW;
                        end
                    end
                    default: begin
                        if (i_stat.addsub_ovf) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_RANGE;
                        end else begin
                            o_cmd.commit = 1'b1;
                            o_cmd.src    = SRC_ADDSUB;
                        end
                    end
                endcase
            end
            S_MULCHK: begin
                if (i_stat.mul_ovf) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_RANGE;
                end else begin
                    o_cmd.commit = 1'b1;
                    o_cmd.src    = SRC_MUL;
                end
                n_state = S_RESP;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.src    = SRC_DIV;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== src/rpn_stack_evaluator.sv =====
// Top level of the RPN stack evaluator: joins the controller and datapath.
// Depends on rse_pkg, rse_ctrl and rse_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The evaluator takes one reverse Polish token per input item and returns
// exactly one result item for each. A digit token pushes its value, and an
// operator pops two operands and pushes their signed 32-bit sum, difference,
// product or truncated quotient. The end token reports the final value and
// empties the stack for the next expression. The first error is latched and
// later tokens are ignored until the end token, which reports the error. For
// tokens other than end, the result carries the latched error and the top of
// the stack after the token (zero when the stack is empty). Items are handled
// one at a time. After the edge that accepts an item, a push, an end, an
// ignored token or an error found at decode passes through decode to the
// response step, an add or subtract through decode, execute and response,
// a multiply also through a range check of the registered product, and a
// divide waits in its own state for the iterative divider, which produces
// one quotient bit per cycle. A divide by zero or the one overflowing divide
// is caught in the execute step. The input is ready again in the cycle after
// the result is loaded. The top of the stack is cached in a register, so
// each operator does one read of the stack memory for its second operand.
// The stack memory needs no clearing after reset, since only entries below
// the count are read. The output register lets the next item be accepted
// while a result waits; that item then stalls in its response step until the
// waiting result is taken.
module rpn_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_cmd,
    input  wire logic [3:0]                    i_digit,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_status,
    output logic signed [rse_pkg::DATA_W-1:0]  o_value,
    output logic                               o_finished
);
    import rse_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_tok_cmd   (i_cmd),
        .i_tok_digit (i_digit),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_finished  (o_finished)
    );

endmodule

`default_nettype wire

// ===== verif/tb_rpn_stack_evaluator.sv =====
// Self-checking testbench for the RPN stack evaluator.
// Depends on rse_pkg and rpn_stack_evaluator, and through it on the other source files.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;

    import rse_pkg::*;

    localparam int unsigned STACK_DEPTH    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned MAX_PRINTED    = 200;

    // The token code that the package leaves unnamed; the block treats it as malformed.
    localparam t_cmd_code CMD_UNUSED = 3'd7;

    // One token to send. When has_want is set, the expected result is the one
    // typed into the row, otherwise the evaluator model supplies it.
    typedef struct packed {
        t_cmd_code         cmd;
        logic [3:0]        digit;
        logic              has_want;
        t_status           status;
        logic [DATA_W-1:0] value;
        logic              finished;
    } t_token;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] value;
        logic              finished;
    } t_result;

    // Directed tokens. Rows with typed results cover the reset state, underflow, divide
    // by zero, malformed, incomplete and first-error latching. The rest exercise
    // every operator, digits above nine and truncation of a negative quotient.
    localparam int unsigned N_DIRECTED = 25;
    localparam t_token DIRECTED_TOKENS [N_DIRECTED] = '{
        '{CMD_END,       4'd0,  1'b1, ST_INCOMPLETE, 32'd0,  1'b1},
        '{CMD_ADD,       4'd0,  1'b1, ST_UNDERFLOW,  32'd0,  1'b0},
        '{CMD_DIGIT,     4'd5,  1'b1, ST_UNDERFLOW,  32'd0,  1'b0},
        '{CMD_END,       4'd0,  1'b1, ST_UNDERFLOW,  32'd0,  1'b1},
        '{CMD_DIGIT,     4'd15, 1'b1, ST_OK,         32'd15, 1'b0},
        '{CMD_DIGIT,     4'd0,  1'b1, ST_OK,         32'd0,  1'b0},
        '{CMD_DIV,       4'd0,  1'b1, ST_DIVZERO,    32'd0,  1'b0},
        '{CMD_END,       4'd0,  1'b1, ST_DIVZERO,    32'd0,  1'b1},
        '{CMD_DIGIT,     4'd9,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_DIGIT,     4'd15, 1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_SUB,       4'd0,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_DIGIT,     4'd7,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_MUL,       4'd0,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_DIGIT,     4'd4,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_DIV,       4'd0,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_DIGIT,     4'd8,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_ADD,       4'd0,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_END,       4'd0,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_DIGIT,     4'd1,  1'b1, ST_OK,         32'd1,  1'b0},
        '{CMD_MALFORMED, 4'd0,  1'b1, ST_MALFORMED,  32'd1,  1'b0},
        '{CMD_END,       4'd0,  1'b1, ST_MALFORMED,  32'd0,  1'b1},
        '{CMD_UNUSED,    4'd0,  1'b1, ST_MALFORMED,  32'd0,  1'b0},
        '{CMD_END,       4'd0,  1'b1, ST_MALFORMED,  32'd0,  1'b1},
        '{CMD_DIGIT,     4'd3,  1'b0, ST_OK,         32'd0,  1'b0},
        '{CMD_END,       4'd0,  1'b0, ST_OK,         32'd0,  1'b0}
    };

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic [2:0]                i_cmd       = '0;
    logic [3:0]                i_digit     = '0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [2:0]                o_status;
    logic signed [DATA_W-1:0]  o_value;
    logic                      o_finished;

    rpn_stack_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_digit     (i_digit),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_finished  (o_finished)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Evaluator model state, kept in step with the tokens the block accepts.
    logic [DATA_W-1:0] model_stack [STACK_DEPTH];
    int unsigned       model_depth = 0;
    t_status           model_err   = ST_OK;

    t_result     expected_results [$];
    t_token      token_plan [$];
    int unsigned counted_tokens = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    bit          rx_hold_req    = 1'b0;

    // Applies one token to the model and returns the result it should cause.
    function automatic t_result eval_token(t_cmd_code cmd, logic [3:0] digit);
        t_result res;
        longint  lhs;
        longint  rhs;
        longint  acc;
        res.finished = 1'b0;
        if (cmd == CMD_END) begin
            res.status   = model_err;
            res.value    = '0;
            res.finished = 1'b1;
            if (model_err == ST_OK) begin
                if (model_depth == 1) begin
                    res.value = model_stack[0];
                end else begin
                    res.status = ST_INCOMPLETE;
                end
            end
            model_depth = 0;
            model_err   = ST_OK;
            return res;
        end
        // While an error is latched, every token but end is ignored.
        if (model_err == ST_OK) begin
            case (cmd)
                CMD_DIGIT: begin
                    if (model_depth >= STACK_DEPTH) begin
                        model_err = ST_FULL;
                    end else begin
                        model_stack[model_depth] = {{(DATA_W-4){1'b0}}, digit};
                        model_depth++;
                    end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                    if (model_depth < 2) begin
                        model_err = ST_UNDERFLOW;
                    end else begin
                        rhs = longint'($signed(model_stack[model_depth-1]));
                        lhs = longint'($signed(model_stack[model_depth-2]));
                        acc = 0;
                        case (cmd)
                            CMD_ADD: acc = lhs + rhs;
                            CMD_SUB: acc = lhs - rhs;
                            CMD_MUL: acc = lhs * rhs;
                            default: begin
                                if (rhs == 0) begin
                                    model_err = ST_DIVZERO;
                                end else begin
                                    acc = lhs / rhs;
                                end
                            end
                        endcase
                        // The stack only changes when the result fits in 32 bits.
                        if (model_err == ST_OK) begin
                            if (acc != longint'($signed(acc[DATA_W-1:0]))) begin
                                model_err = ST_RANGE;
                            end else begin
                                model_depth--;
                                model_stack[model_depth-1] = acc[DATA_W-1:0];
                            end
                        end
                    end
                end
                default: model_err = ST_MALFORMED;
            endcase
        end
        res.status = model_err;
        res.value  = (model_depth == 0) ? '0 : model_stack[model_depth-1];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (mismatches < MAX_PRINTED) begin
            $display("result %0d: %s is %0d, expected %0d", results_seen, field,
                     $signed(got), $signed(want));
        end
        mismatches++;
    endtask

    function automatic void plan_token(t_cmd_code cmd, logic [3:0] digit);
        token_plan.push_back(t_token'{cmd, digit, 1'b0, ST_OK, '0, 1'b0});
    endfunction

    function automatic void plan_noise_token();
        plan_token(t_cmd_code'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    endfunction

    // Two raised to the thirtieth power, built as repeated doubling of a two.
    function automatic void plan_power30();
        plan_token(CMD_DIGIT, 4'd2);
        repeat (29) begin
            plan_token(CMD_DIGIT, 4'd2);
            plan_token(CMD_MUL, 4'd0);
        end
    endfunction

    // Expressions that reach the ends of the signed 32-bit range, and step over them.
    function automatic void plan_extreme(int unsigned variant);
        if (variant <= 2) begin
            // The most negative value: (0 - 2^30) * 2.
            plan_token(CMD_DIGIT, 4'd0);
            plan_power30();
            plan_token(CMD_SUB, 4'd0);
            plan_token(CMD_DIGIT, 4'd2);
            plan_token(CMD_MUL, 4'd0);
            if (variant == 1) begin
                // Divided by minus one, its quotient does not fit.
                plan_token(CMD_DIGIT, 4'd0);
                plan_token(CMD_DIGIT, 4'd1);
                plan_token(CMD_SUB, 4'd0);
                plan_token(CMD_DIV, 4'd0);
            end else if (variant == 2) begin
                plan_token(CMD_DIGIT, 4'd1);
                plan_token(CMD_SUB, 4'd0);
            end
        end else begin
            // The most positive value: (2^30 - 1) + 2^30.
            plan_power30();
            plan_token(CMD_DIGIT, 4'd1);
            plan_token(CMD_SUB, 4'd0);
            plan_power30();
            plan_token(CMD_ADD, 4'd0);
            if (variant == 4) begin
                plan_token(CMD_DIGIT, 4'd1);
                plan_token(CMD_ADD, 4'd0);
            end
        end
        plan_token(CMD_END, 4'd0);
    endfunction

    // A well-formed expression with random digits and operators, with now and
    // then a stray token mixed in. A product-heavy one tends to leave the range.
    function automatic void plan_expression(bit mul_heavy);
        int unsigned operands_left;
        int unsigned depth;
        operands_left = mul_heavy ? $urandom_range(4, 12) : $urandom_range(1, 8);
        depth = 0;
        while (operands_left > 0 || depth > 1) begin
            if ($urandom_range(0, 99) < 6) begin
                plan_noise_token();
            end
            if (depth < 2 || (operands_left > 0 && $urandom_range(0, 1) == 1)) begin
                plan_token(CMD_DIGIT, mul_heavy ? 4'($urandom_range(8, 15))
                                                : 4'($urandom_range(0, 15)));
                operands_left--;
                depth++;
            end else begin
                if (mul_heavy && $urandom_range(0, 3) != 0) begin
                    plan_token(CMD_MUL, 4'd0);
                end else begin
                    plan_token(t_cmd_code'($urandom_range(CMD_ADD, CMD_DIV)), 4'd0);
                end
                depth--;
            end
        end
        plan_token(CMD_END, 4'd0);
    endfunction

    // Pushes from two below to three past the stack limit and then ends the expression.
    function automatic void plan_deep_stack();
        int unsigned pushes;
        pushes = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
        repeat (pushes) plan_token(CMD_DIGIT, 4'($urandom_range(0, 15)));
        repeat ($urandom_range(0, 3)) plan_token(t_cmd_code'($urandom_range(CMD_ADD, CMD_MUL)),
                                                4'd0);
        plan_token(CMD_END, 4'd0);
    endfunction

    // Offers one item after a random gap and waits until the block takes it.
    // The expected result is queued at the edge where the item is accepted.
    task automatic send_token(t_token tok);
        t_result want;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            i_cmd      <= 3'($urandom_range(0, 7));
            i_digit    <= 4'($urandom_range(0, 15));
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= tok.cmd;
        i_digit    <= tok.digit;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        counted_tokens++;
        want = eval_token(tok.cmd, tok.digit);
        if (tok.has_want) begin
            want = t_result'{tok.status, tok.value, tok.finished};
        end
        expected_results.push_back(want);
    endtask

    task automatic send_plan();
        while (token_plan.size() != 0) begin
            send_token(token_plan.pop_front());
        end
    endtask

    // Result side: ready is redrawn every cycle from the current idle share.
    // A hold request keeps it low for a long stretch so that the block backs
    // up and stalls its input while the sender keeps offering items.
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Checks each accepted result against the oldest expectation, and ends the
    // run if no item moves on either channel for too long.
    initial begin : result_check
        t_result     want;
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result value", o_value, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                    end
                    if (o_value !== want.value) begin
                        report_mismatch("value", o_value, want.value);
                    end
                    if (o_finished !== want.finished) begin
                        report_mismatch("finished", DATA_W'(o_finished),
                                        DATA_W'(want.finished));
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with light idling on both sides.
        tx_idle_pct = 8;
        rx_idle_pct = 8;
        for (int unsigned row = 0; row < N_DIRECTED; row++) begin
            send_token(DIRECTED_TOKENS[row]);
        end

        // Random part in three phases: a slow receiver, then a slow sender,
        // then no idling at all with one long receiver hold-off.
        for (int unsigned phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 82;
                end
                1: begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 8;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    rx_hold_req = 1'b1;
                end
            endcase
            // Each phase takes its share of the range-edge expressions first.
            for (int unsigned variant = 2 * phase; variant < 2 * phase + 2; variant++) begin
                if (variant <= 4) begin
                    plan_extreme(variant);
                end
            end
            send_plan();
            while (counted_tokens < (phase + 1) * 420) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    plan_expression(1'b0);
                end else if (pick < 72) begin
                    plan_expression(1'b1);
                end else if (pick < 92) begin
                    repeat ($urandom_range(1, 10)) plan_noise_token();
                    plan_token(CMD_END, 4'd0);
                end else begin
                    plan_deep_stack();
                end
                send_plan();
            end
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rse_pkg.sv
src/rse_div.sv
src/rse_datapath.sv
src/rse_ctrl.sv
src/rpn_stack_evaluator.sv
verif/tb_rpn_stack_evaluator.sv
